// ===== rtl/core/aabb_pair_collision_resolve_defines.svh =====
// Assertion macros shared by the box pair collision RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef AABB_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`define AABB_PAIR_COLLISION_RESOLVE_DEFINES_SVH

// Property on clk_i, disabled while rst_ni is low.
`define AABB_PCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, with explicit clock and active-low reset.
`define AABB_PCR_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== rtl/core/aabb_pcr_pkg.sv =====
// Package for the box pair collision resolver: default coordinate width and
// the flag structs passed between the top level and the resolve logic.
package aabb_pcr_pkg;

  localparam int unsigned CoordBitsDefault = 16;

  typedef struct packed {
    logic solid;
    logic movable;
  } box_flags_t;

  typedef struct packed {
    logic overlapping;
    logic a_clear_vy;
    logic b_clear_vy;
    logic a_grounded_set;
    logic b_grounded_set;
  } res_flags_t;

endpackage

// ===== rtl/core/aabb_pair_collision_resolve.sv =====
// Top level of the box pair collision resolver: input register, resolve logic,
// result register. Depends on aabb_pcr_pkg, aabb_pcr_resolve and the defines header.
//
// One box pair is accepted per transaction and one result comes back for each.
// The block takes a new pair every cycle while the output is not stalled; the result
// reaches the output after passing the input register and then the result register,
// around a single combinational resolve pass. Output stalls hold the result
// register and back-pressure the input once the input register is also full.
module aabb_pair_collision_resolve import aabb_pcr_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic        [COORD_BITS-2:0] a_width_i,
  input  logic        [COORD_BITS-2:0] a_height_i,
  input  logic                         a_solid_i,
  input  logic                         a_movable_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic        [COORD_BITS-2:0] b_width_i,
  input  logic        [COORD_BITS-2:0] b_height_i,
  input  logic                         b_solid_i,
  input  logic                         b_movable_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         overlapping_o,
  output logic signed [COORD_BITS-1:0] new_a_x_o,
  output logic signed [COORD_BITS-1:0] new_a_y_o,
  output logic signed [COORD_BITS-1:0] new_b_x_o,
  output logic signed [COORD_BITS-1:0] new_b_y_o,
  output logic                         a_clear_vy_o,
  output logic                         b_clear_vy_o,
  output logic                         a_grounded_set_o,
  output logic                         b_grounded_set_o
);

  `include "aabb_pair_collision_resolve_defines.svh"

  logic in_valid_q, out_valid_q;
  logic in_en, out_en;
  logic res_push_vy;

  logic signed [COORD_BITS-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic        [COORD_BITS-2:0] a_w_q, a_h_q, b_w_q, b_h_q;
  box_flags_t                   a_flags_q, b_flags_q;

  logic signed [COORD_BITS-1:0] nax_d, nay_d, nbx_d, nby_d;
  logic signed [COORD_BITS-1:0] nax_q, nay_q, nbx_q, nby_q;
  res_flags_t                   flags_d, flags_q;

  assign out_en     = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || out_en;
  assign in_en      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      a_x_q     <= a_x_i;
      a_y_q     <= a_y_i;
      a_w_q     <= a_width_i;
      a_h_q     <= a_height_i;
      a_flags_q <= '{solid: a_solid_i, movable: a_movable_i};
      b_x_q     <= b_x_i;
      b_y_q     <= b_y_i;
      b_w_q     <= b_width_i;
      b_h_q     <= b_height_i;
      b_flags_q <= '{solid: b_solid_i, movable: b_movable_i};
    end
  end

  aabb_pcr_resolve #(
    .COORD_BITS(COORD_BITS)
  ) u_resolve (
    .a_x_i      (a_x_q),
    .a_y_i      (a_y_q),
    .a_width_i  (a_w_q),
    .a_height_i (a_h_q),
    .a_flags_i  (a_flags_q),
    .b_x_i      (b_x_q),
    .b_y_i      (b_y_q),
    .b_width_i  (b_w_q),
    .b_height_i (b_h_q),
    .b_flags_i  (b_flags_q),
    .new_a_x_o  (nax_d),
    .new_a_y_o  (nay_d),
    .new_b_x_o  (nbx_d),
    .new_b_y_o  (nby_d),
    .flags_o    (flags_d)
  );

  always_ff @(posedge clk_i) begin
    if (out_en && in_valid_q) begin
      nax_q   <= nax_d;
      nay_q   <= nay_d;
      nbx_q   <= nbx_d;
      nby_q   <= nby_d;
      flags_q <= flags_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign overlapping_o    = flags_q.overlapping;
  assign new_a_x_o        = nax_q;
  assign new_a_y_o        = nay_q;
  assign new_b_x_o        = nbx_q;
  assign new_b_y_o        = nby_q;
  assign a_clear_vy_o     = flags_q.a_clear_vy;
  assign b_clear_vy_o     = flags_q.b_clear_vy;
  assign a_grounded_set_o = flags_q.a_grounded_set;
  assign b_grounded_set_o = flags_q.b_grounded_set;

  assign res_push_vy = out_valid_o && (a_clear_vy_o || b_clear_vy_o);

  `AABB_PCR_ASSERT(a_one_box_moved, out_valid_o |-> !(a_clear_vy_o && b_clear_vy_o), "both pushed")
  `AABB_PCR_ASSERT(a_flags_need_hit, res_push_vy |-> overlapping_o, "push flag without overlap")
  `AABB_PCR_ASSERT(a_ground_a, out_valid_o && a_grounded_set_o |-> a_clear_vy_o, "A not pushed")
  `AABB_PCR_ASSERT(a_ground_b, out_valid_o && b_grounded_set_o |-> b_clear_vy_o, "B not pushed")
  `AABB_PCR_ASSERT(a_pipe_advance, (in_valid_q && out_en) |=> out_valid_o, "transaction lost")

endmodule

// ===== rtl/core/aabb_pcr_resolve.sv =====
// Combinational overlap test and minimum-axis push-out for one box pair.
// Depends on aabb_pcr_pkg for the flag structs.
module aabb_pcr_resolve import aabb_pcr_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic        [COORD_BITS-2:0] a_width_i,
  input  logic        [COORD_BITS-2:0] a_height_i,
  input  box_flags_t                   a_flags_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic        [COORD_BITS-2:0] b_width_i,
  input  logic        [COORD_BITS-2:0] b_height_i,
  input  box_flags_t                   b_flags_i,
  output logic signed [COORD_BITS-1:0] new_a_x_o,
  output logic signed [COORD_BITS-1:0] new_a_y_o,
  output logic signed [COORD_BITS-1:0] new_b_x_o,
  output logic signed [COORD_BITS-1:0] new_b_y_o,
  output res_flags_t                   flags_o
);

  localparam int unsigned W = COORD_BITS;
  localparam int unsigned E = COORD_BITS + 3;
  localparam int unsigned Pad = E - (COORD_BITS - 1);

  localparam logic signed [E-1:0] CoordMax = E'(signed'({1'b0, {(W-1){1'b1}}}));
  localparam logic signed [E-1:0] CoordMin = E'(signed'({1'b1, {(W-1){1'b0}}}));

  function automatic logic signed [W-1:0] sat(input logic signed [E-1:0] v);
    logic signed [W-1:0] r;
    if (v > CoordMax) begin
      r = CoordMax[W-1:0];
    end else if (v < CoordMin) begin
      r = CoordMin[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  logic signed [E-1:0] ax, ay, bx, by;
  logic signed [E-1:0] aw, ah, bw, bh;
  logic signed [E-1:0] a_r, a_b, b_r, b_b;
  logic signed [E-1:0] min_r, max_l, min_b, max_t;
  logic signed [E-1:0] ox, oy;
  logic signed [E-1:0] nax, nay, nbx, nby;
  logic                hit, push, push_x, a_left, a_above;
  logic                am, bm;

  assign ax = E'(a_x_i);
  assign ay = E'(a_y_i);
  assign bx = E'(b_x_i);
  assign by = E'(b_y_i);
  assign aw = signed'({{Pad{1'b0}}, a_width_i});
  assign ah = signed'({{Pad{1'b0}}, a_height_i});
  assign bw = signed'({{Pad{1'b0}}, b_width_i});
  assign bh = signed'({{Pad{1'b0}}, b_height_i});

  assign a_r = ax + aw;
  assign a_b = ay + ah;
  assign b_r = bx + bw;
  assign b_b = by + bh;

  assign hit = (ax < b_r) && (a_r > bx) && (ay < b_b) && (a_b > by);
  assign push = hit && (a_flags_i.solid || b_flags_i.solid);

  assign min_r = (a_r < b_r) ? a_r : b_r;
  assign max_l = (ax > bx) ? ax : bx;
  assign min_b = (a_b < b_b) ? a_b : b_b;
  assign max_t = (ay > by) ? ay : by;
  assign ox = min_r - max_l;
  assign oy = min_b - max_t;

  assign push_x  = ox < oy;
  assign a_left  = ax < bx;
  assign a_above = ay < by;
  assign am = a_flags_i.movable;
  assign bm = b_flags_i.movable;

  always_comb begin
    nax = ax;
    nay = ay;
    nbx = bx;
    nby = by;
    flags_o = '0;
    flags_o.overlapping = hit;
    if (push) begin
      if (push_x) begin
        if (am) begin
          nax = a_left ? ax - ox : ax + ox;
        end else if (bm) begin
          nbx = a_left ? bx + ox : bx - ox;
        end
      end else begin
        if (am) begin
          nay = a_above ? ay - oy : ay + oy;
          flags_o.a_clear_vy = 1'b1;
          flags_o.a_grounded_set = a_above && !bm;
        end else if (bm) begin
          nby = a_above ? by + oy : by - oy;
          flags_o.b_clear_vy = 1'b1;
          flags_o.b_grounded_set = a_above;
        end
      end
    end
  end

  assign new_a_x_o = sat(nax);
  assign new_a_y_o = sat(nay);
  assign new_b_x_o = sat(nbx);
  assign new_b_y_o = sat(nby);

endmodule

// ===== verif/aabb_pair_collision_resolve_tb.sv =====
// Testbench for aabb_pair_collision_resolve: directed and random box pairs, every result
// checked against an in-bench model of overlap, push-out, velocity and grounded flags.
// Depends on aabb_pcr_pkg and the aabb_pair_collision_resolve RTL only.
module aabb_pair_collision_resolve_tb import aabb_pcr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = CoordBitsDefault;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic        [CW-2:0] w;
    logic        [CW-2:0] h;
    box_flags_t           flags;
  } box_t;

  typedef struct {
    res_flags_t           flags;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
  } push_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [CW-1:0] a_x_i = '0;
  logic signed [CW-1:0] a_y_i = '0;
  logic        [CW-2:0] a_width_i = '0;
  logic        [CW-2:0] a_height_i = '0;
  logic                 a_solid_i = 1'b0;
  logic                 a_movable_i = 1'b0;
  logic signed [CW-1:0] b_x_i = '0;
  logic signed [CW-1:0] b_y_i = '0;
  logic        [CW-2:0] b_width_i = '0;
  logic        [CW-2:0] b_height_i = '0;
  logic                 b_solid_i = 1'b0;
  logic                 b_movable_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b1;
  logic                 overlapping_o;
  logic signed [CW-1:0] new_a_x_o;
  logic signed [CW-1:0] new_a_y_o;
  logic signed [CW-1:0] new_b_x_o;
  logic signed [CW-1:0] new_b_y_o;
  logic                 a_clear_vy_o;
  logic                 b_clear_vy_o;
  logic                 a_grounded_set_o;
  logic                 b_grounded_set_o;

  push_result_t pending_results[$];
  int           mismatches = 0;
  bit           gaps_on = 1'b0;
  int           burst_left = 0;
  logic [15:0]  ready_pattern = 16'hffff;
  int           pattern_age = 0;

  aabb_pair_collision_resolve #(
    .COORD_BITS(CW)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .a_x_i           (a_x_i),
    .a_y_i           (a_y_i),
    .a_width_i       (a_width_i),
    .a_height_i      (a_height_i),
    .a_solid_i       (a_solid_i),
    .a_movable_i     (a_movable_i),
    .b_x_i           (b_x_i),
    .b_y_i           (b_y_i),
    .b_width_i       (b_width_i),
    .b_height_i      (b_height_i),
    .b_solid_i       (b_solid_i),
    .b_movable_i     (b_movable_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .overlapping_o   (overlapping_o),
    .new_a_x_o       (new_a_x_o),
    .new_a_y_o       (new_a_y_o),
    .new_b_x_o       (new_b_x_o),
    .new_b_y_o       (new_b_y_o),
    .a_clear_vy_o    (a_clear_vy_o),
    .b_clear_vy_o    (b_clear_vy_o),
    .a_grounded_set_o(a_grounded_set_o),
    .b_grounded_set_o(b_grounded_set_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("aabb_pair_collision_resolve verification failed");
    $finish;
  end

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  function automatic box_t mk_box(longint x, longint y, longint w, longint h,
                                  bit solid, bit movable);
    box_t b;
    b.x = x[CW-1:0];
    b.y = y[CW-1:0];
    b.w = w[CW-2:0];
    b.h = h[CW-2:0];
    b.flags.solid = solid;
    b.flags.movable = movable;
    return b;
  endfunction

  function automatic push_result_t resolve_pair(box_t a, box_t b);
    longint ax, ay, aw, ah, bx, by, bw, bh, ox, oy, nax, nay, nbx, nby;
    push_result_t r;
    ax = a.x; ay = a.y; aw = a.w; ah = a.h;
    bx = b.x; by = b.y; bw = b.w; bh = b.h;
    nax = ax; nay = ay; nbx = bx; nby = by;
    r.flags = '0;
    r.flags.overlapping = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
    if (r.flags.overlapping && (a.flags.solid || b.flags.solid)) begin
      ox = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - ((ax > bx) ? ax : bx);
      oy = ((ay + ah < by + bh) ? ay + ah : by + bh) - ((ay > by) ? ay : by);
      if (ox < oy) begin
        if (ax < bx) begin
          if (a.flags.movable) nax = ax - ox;
          else if (b.flags.movable) nbx = bx + ox;
        end else begin
          if (a.flags.movable) nax = ax + ox;
          else if (b.flags.movable) nbx = bx - ox;
        end
      end else if (ay < by) begin
        if (a.flags.movable) begin
          nay = ay - oy;
          r.flags.a_clear_vy = 1'b1;
          r.flags.a_grounded_set = !b.flags.movable;
        end else if (b.flags.movable) begin
          nby = by + oy;
          r.flags.b_clear_vy = 1'b1;
          r.flags.b_grounded_set = 1'b1;
        end
      end else begin
        if (a.flags.movable) begin
          nay = ay + oy;
          r.flags.a_clear_vy = 1'b1;
        end else if (b.flags.movable) begin
          nby = by - oy;
          r.flags.b_clear_vy = 1'b1;
        end
      end
    end
    r.a_x = clamp_coord(nax);
    r.a_y = clamp_coord(nay);
    r.b_x = clamp_coord(nbx);
    r.b_y = clamp_coord(nby);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pair(box_t a, box_t b);
    if (gaps_on && burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    a_x_i = a.x; a_y_i = a.y; a_width_i = a.w; a_height_i = a.h;
    a_solid_i = a.flags.solid; a_movable_i = a.flags.movable;
    b_x_i = b.x; b_y_i = b.y; b_width_i = b.w; b_height_i = b.h;
    b_solid_i = b.flags.solid; b_movable_i = b.flags.movable;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(resolve_pair(a, b));
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  // Receiver stall pattern, rotated at each falling edge and reloaded when pattern_age wraps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i = ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hffff;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'($urandom & $urandom);
        endcase
        if (ready_pattern == '0) ready_pattern = 16'h0001;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    push_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (overlapping_o !== want.flags.overlapping)
          report_mismatch("overlapping", overlapping_o, want.flags.overlapping);
        if (new_a_x_o !== want.a_x) report_mismatch("new_a_x", new_a_x_o, want.a_x);
        if (new_a_y_o !== want.a_y) report_mismatch("new_a_y", new_a_y_o, want.a_y);
        if (new_b_x_o !== want.b_x) report_mismatch("new_b_x", new_b_x_o, want.b_x);
        if (new_b_y_o !== want.b_y) report_mismatch("new_b_y", new_b_y_o, want.b_y);
        if (a_clear_vy_o !== want.flags.a_clear_vy)
          report_mismatch("a_clear_vy", a_clear_vy_o, want.flags.a_clear_vy);
        if (b_clear_vy_o !== want.flags.b_clear_vy)
          report_mismatch("b_clear_vy", b_clear_vy_o, want.flags.b_clear_vy);
        if (a_grounded_set_o !== want.flags.a_grounded_set)
          report_mismatch("a_grounded_set", a_grounded_set_o, want.flags.a_grounded_set);
        if (b_grounded_set_o !== want.flags.b_grounded_set)
          report_mismatch("b_grounded_set", b_grounded_set_o, want.flags.b_grounded_set);
      end
    end
  end

  task automatic test_separated();
    send_pair(mk_box(0, 0, 16, 16, 1, 1), mk_box(16, 0, 16, 16, 1, 1));
    send_pair(mk_box(0, 0, 16, 16, 1, 1), mk_box(0, 16, 16, 16, 1, 1));
    send_pair(mk_box(-32768, -32768, 32767, 32767, 1, 1),
              mk_box(32767, 32767, 32767, 32767, 1, 1));
    send_pair(mk_box(32767, 32767, 32767, 32767, 1, 1),
              mk_box(-32768, -32768, 32767, 32767, 1, 1));
    // zero-width box inside the other still counts as overlapping
    send_pair(mk_box(8, 8, 0, 16, 1, 1), mk_box(0, 0, 32, 32, 1, 1));
  endtask

  task automatic test_solid_movable_flags();
    send_pair(mk_box(0, 0, 32, 32, 0, 1), mk_box(8, 4, 32, 32, 0, 1));
    send_pair(mk_box(0, 0, 32, 32, 1, 0), mk_box(8, 4, 32, 32, 1, 0));
    send_pair(mk_box(0, 0, 32, 32, 0, 1), mk_box(8, 4, 32, 32, 1, 0));
  endtask

  task automatic test_horizontal_push();
    send_pair(mk_box(0, 0, 32, 32, 1, 1), mk_box(8, 4, 32, 32, 1, 1));
    send_pair(mk_box(0, 0, 32, 32, 1, 0), mk_box(8, 4, 32, 32, 1, 1));
    send_pair(mk_box(8, 4, 32, 32, 1, 1), mk_box(0, 0, 32, 32, 1, 1));
    send_pair(mk_box(8, 4, 32, 32, 0, 0), mk_box(0, 0, 32, 32, 1, 1));
  endtask

  task automatic test_vertical_push();
    send_pair(mk_box(0, 0, 32, 32, 1, 1), mk_box(4, 8, 32, 32, 1, 1));
    send_pair(mk_box(0, 0, 32, 32, 1, 1), mk_box(4, 8, 32, 32, 1, 0));
    send_pair(mk_box(0, 0, 32, 32, 1, 0), mk_box(4, 8, 32, 32, 0, 1));
    send_pair(mk_box(4, 8, 32, 32, 0, 1), mk_box(0, 0, 32, 32, 1, 0));
    send_pair(mk_box(4, 8, 32, 32, 1, 0), mk_box(0, 0, 32, 32, 1, 1));
    // equal depth on both axes resolves vertically
    send_pair(mk_box(0, 0, 32, 32, 1, 1), mk_box(8, 8, 32, 32, 1, 1));
  endtask

  task automatic test_saturation();
    send_pair(mk_box(-32760, 0, 100, 1000, 1, 1), mk_box(-32700, 0, 100, 1000, 1, 1));
    send_pair(mk_box(32700, 0, 100, 1000, 1, 0), mk_box(32760, 0, 100, 1000, 1, 1));
    send_pair(mk_box(0, -32760, 1000, 100, 1, 1), mk_box(0, -32700, 1000, 100, 1, 1));
    send_pair(mk_box(0, 32700, 1000, 100, 1, 0), mk_box(0, 32760, 1000, 100, 1, 1));
    send_pair(mk_box(-32768, -32768, 32767, 32767, 1, 1),
              mk_box(-32768, -32768, 32767, 32767, 1, 1));
  endtask

  task automatic test_random_pairs(int count);
    box_t   a;
    box_t   b;
    longint dx;
    longint dy;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      a = mk_box($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      b = mk_box($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) >= 2) begin
        // overlapping or touching pair with mostly modest sizes
        if ($urandom_range(0, 15) != 0) begin
          a.w = (CW-1)'($urandom_range(0, 2047));
          a.h = (CW-1)'($urandom_range(0, 2047));
          b.w = (CW-1)'($urandom_range(0, 2047));
          b.h = (CW-1)'($urandom_range(0, 2047));
        end
        dx = longint'($urandom_range(0, int'(a.w) + int'(b.w))) - longint'(b.w);
        dy = longint'($urandom_range(0, int'(a.h) + int'(b.h))) - longint'(b.h);
        b.x = clamp_coord(longint'(a.x) + dx);
        b.y = clamp_coord(longint'(a.y) + dy);
      end
      send_pair(a, b);
    end
    gaps_on = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_separated();
    test_solid_movable_flags();
    test_horizontal_push();
    test_vertical_push();
    test_saturation();
    test_random_pairs(1000);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("aabb_pair_collision_resolve verification clean");
    end else begin
      $display("aabb_pair_collision_resolve verification failed");
    end
    $finish;
  end

endmodule
